[sv/c_lexer_token_scanner_assert.svh]
// ----------------------------------------------------------------------------
// c_lexer_token_scanner_assert
// assertion macros for the token scanner
// ----------------------------------------------------------------------------
`ifndef C_LEXER_TOKEN_SCANNER_ASSERT_SVH
`define C_LEXER_TOKEN_SCANNER_ASSERT_SVH

// condition checked at every clock edge outside reset
`define CLTS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequence checked in the cycle after the trigger
`define CLTS_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[sv/clts_pkg.sv]
// ----------------------------------------------------------------------------
// clts_pkg
// token record, class codes and keyword table of the c token scanner
// ----------------------------------------------------------------------------
package clts_pkg;

    localparam int KwMaxChars = 8;
    localparam int KwCount    = 32;

    localparam logic [3:0] CLS_ID      = 4'd0;
    localparam logic [3:0] CLS_INT     = 4'd1;
    localparam logic [3:0] CLS_FLOAT   = 4'd2;
    localparam logic [3:0] CLS_CHAR    = 4'd3;
    localparam logic [3:0] CLS_STRING  = 4'd4;
    localparam logic [3:0] CLS_OP      = 4'd5;
    localparam logic [3:0] CLS_DELIM   = 4'd6;
    localparam logic [3:0] CLS_KEYWORD = 4'd7;
    localparam logic [3:0] CLS_ERROR   = 4'd8;

    localparam logic [5:0]  NOT_KEYWORD = 6'd32;
    localparam logic [19:0] LINE_MAX    = 20'hFFFFF;
    localparam logic [15:0] COL_MAX     = 16'hFFFF;
    localparam logic [15:0] LEN_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [15:0] length;
        logic [31:0] offset;
        logic [15:0] col;
        logic [19:0] line;
        logic [5:0]  kw;
        logic [3:0]  cls;
    } t_tok;

    // first character in the highest used byte
    localparam logic [63:0] KW_TEXT [KwCount] = '{
        64'("auto"), 64'("short"), 64'("int"), 64'("long"), 64'("float"),
        64'("double"), 64'("char"), 64'("struct"), 64'("union"), 64'("enum"),
        64'("typedef"), 64'("const"), 64'("unsigned"), 64'("signed"),
        64'("extern"), 64'("register"), 64'("static"), 64'("volatile"),
        64'("void"), 64'("if"), 64'("else"), 64'("switch"), 64'("case"),
        64'("default"), 64'("for"), 64'("do"), 64'("while"), 64'("continue"),
        64'("break"), 64'("goto"), 64'("sizeof"), 64'("return")
    };

    localparam logic [3:0] KW_LEN [KwCount] = '{
        4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd6, 4'd4, 4'd6, 4'd5, 4'd4, 4'd7,
        4'd5, 4'd8, 4'd6, 4'd6, 4'd8, 4'd6, 4'd8, 4'd4, 4'd2, 4'd4, 4'd6,
        4'd4, 4'd7, 4'd3, 4'd2, 4'd5, 4'd8, 4'd5, 4'd4, 4'd6, 4'd6
    };

    function automatic logic [5:0] kw_lookup(input logic [7:0] word_q [KwMaxChars],
                                             input logic [15:0] len,
                                             input logic too_long);
        logic [5:0] res;
        logic       hit;
        res = NOT_KEYWORD;
        for (int i = KwCount - 1; i >= 0; i--) begin
            hit = !too_long && ({12'd0, KW_LEN[i]} == len);
            for (int k = 0; k < KwMaxChars; k++) begin
                if (k < int'(KW_LEN[i]) &&
                    word_q[k] != KW_TEXT[i][8*(int'(KW_LEN[i]) - 1 - k) +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                res = 6'(i);
            end
        end
        return res;
    endfunction

endpackage

[sv/clts_lexer.sv]
// ----------------------------------------------------------------------------
// clts_lexer
// lexer state, position counters and token decision for one byte
// ----------------------------------------------------------------------------
module clts_lexer
    import clts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char,
    input  logic       i_eoi,
    output logic       o_va,
    output t_tok       o_tok_a,
    output logic       o_vb,
    output t_tok       o_tok_b
);

    typedef enum logic [4:0] {
        S_BEGIN, S_WORD, S_INT, S_FRAC1, S_FRAC, S_EXP1, S_EXP2, S_EXP,
        S_PLUS, S_MINUS, S_SLASH, S_STAR, S_PCT, S_AMP, S_BAR, S_BANG,
        S_GT, S_GTGT, S_LT, S_LTLT, S_CARET, S_EQ,
        S_CHR, S_CHR_ESC, S_STR, S_STR_ESC, S_BLOCK, S_BLOCK_STAR, S_LINE
    } t_lex_state;

    t_lex_state  r_state, n_state;
    logic [7:0]  r_word [KwMaxChars];
    logic [7:0]  n_word [KwMaxChars];
    logic        r_too_long, n_too_long;
    logic [15:0] r_len, n_len;
    logic [19:0] r_line, n_line;
    logic [15:0] r_col, n_col;
    logic [31:0] r_off, n_off;
    logic [19:0] r_tline, n_tline;
    logic [15:0] r_tcol, n_tcol;
    logic [31:0] r_toff, n_toff;

    logic [15:0] len_inc;
    logic [15:0] ncol;
    logic [5:0]  kw_idx;
    logic        is_letter, is_digit, is_e, rebegin;
    logic [7:0]  op_first;

    assign is_letter = (i_char >= "a" && i_char <= "z") || (i_char >= "A" && i_char <= "Z")
                       || i_char == "_";
    assign is_digit  = i_char >= "0" && i_char <= "9";
    assign is_e      = i_char == "e" || i_char == "E";
    assign len_inc   = (r_len < LEN_MAX) ? r_len + 16'd1 : r_len;
    assign kw_idx    = kw_lookup(r_word, r_len, r_too_long);

    always_comb begin
        unique case (r_state)
            S_PLUS:  op_first = "+";
            S_MINUS: op_first = "-";
            S_AMP:   op_first = "&";
            S_BAR:   op_first = "|";
            S_GT:    op_first = ">";
            S_LT:    op_first = "<";
            default: op_first = 8'd0;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_word     = r_word;
        n_too_long = r_too_long;
        n_len      = r_len;
        n_line     = r_line;
        n_col      = r_col;
        n_off      = r_off;
        n_tline    = r_tline;
        n_tcol     = r_tcol;
        n_toff     = r_toff;
        rebegin    = 1'b0;
        ncol       = 16'd0;
        o_va       = 1'b0;
        o_vb       = 1'b0;
        o_tok_a    = '{length: r_len, offset: r_toff, col: r_tcol, line: r_tline,
                       kw: NOT_KEYWORD, cls: CLS_ERROR};
        o_tok_b    = o_tok_a;
        if (i_accept) begin
            if (i_eoi) begin
                unique case (r_state)
                    S_WORD: begin
                        o_va = 1'b1;
                        o_tok_a.kw  = kw_idx;
                        o_tok_a.cls = (kw_idx == NOT_KEYWORD) ? CLS_ID : CLS_KEYWORD;
                    end
                    S_INT: begin
                        o_va = 1'b1;
                        o_tok_a.cls = CLS_INT;
                    end
                    S_FRAC, S_EXP: begin
                        o_va = 1'b1;
                        o_tok_a.cls = CLS_FLOAT;
                    end
                    S_FRAC1, S_EXP1, S_EXP2, S_CHR, S_CHR_ESC, S_STR, S_STR_ESC: begin
                        o_va = 1'b1;
                    end
                    S_PLUS, S_MINUS, S_SLASH, S_STAR, S_PCT, S_AMP, S_BAR, S_BANG,
                    S_GT, S_GTGT, S_LT, S_LTLT, S_CARET, S_EQ: begin
                        o_va = 1'b1;
                        o_tok_a.cls = CLS_OP;
                    end
                    default: begin
                    end
                endcase
                n_state    = S_BEGIN;
                n_len      = 16'd0;
                n_too_long = 1'b0;
            end else begin
                n_off = r_off + 32'd1;
                if (i_char == 8'h0A) begin
                    n_line = (r_line < LINE_MAX) ? r_line + 20'd1 : r_line;
                    n_col  = 16'd0;
                end else if (r_col < COL_MAX) begin
                    n_col = r_col + 16'd1;
                end
                ncol = (n_col < COL_MAX) ? n_col + 16'd1 : n_col;

                unique case (r_state)
                    S_BEGIN: rebegin = 1'b1;
                    S_WORD: begin
                        if (is_letter || is_digit) begin
                            if (r_len < 16'(KwMaxChars)) begin
                                n_word[r_len[2:0]] = i_char;
                            end else begin
                                n_too_long = 1'b1;
                            end
                            n_len = len_inc;
                        end else begin
                            o_va = 1'b1;
                            o_tok_a.kw  = kw_idx;
                            o_tok_a.cls = (kw_idx == NOT_KEYWORD) ? CLS_ID : CLS_KEYWORD;
                            rebegin = 1'b1;
                        end
                    end
                    S_INT: begin
                        if (is_digit) begin
                            n_len = len_inc;
                        end else if (i_char == ".") begin
                            n_len = len_inc;
                            n_state = S_FRAC1;
                        end else if (is_e) begin
                            n_len = len_inc;
                            n_state = S_EXP1;
                        end else begin
                            o_va = 1'b1;
                            o_tok_a.cls = CLS_INT;
                            rebegin = 1'b1;
                        end
                    end
                    S_FRAC1: begin
                        if (is_digit) begin
                            n_len = len_inc;
                            n_state = S_FRAC;
                        end else begin
                            o_va = 1'b1;
                            rebegin = 1'b1;
                        end
                    end
                    S_FRAC: begin
                        if (is_digit) begin
                            n_len = len_inc;
                        end else if (is_e) begin
                            n_len = len_inc;
                            n_state = S_EXP1;
                        end else begin
                            o_va = 1'b1;
                            o_tok_a.cls = CLS_FLOAT;
                            rebegin = 1'b1;
                        end
                    end
                    S_EXP1: begin
                        if (i_char == "+" || i_char == "-") begin
                            n_len = len_inc;
                            n_state = S_EXP2;
                        end else if (is_digit) begin
                            n_len = len_inc;
                            n_state = S_EXP;
                        end else begin
                            o_va = 1'b1;
                            rebegin = 1'b1;
                        end
                    end
                    S_EXP2: begin
                        if (is_digit) begin
                            n_len = len_inc;
                            n_state = S_EXP;
                        end else begin
                            o_va = 1'b1;
                            rebegin = 1'b1;
                        end
                    end
                    S_EXP: begin
                        if (is_digit) begin
                            n_len = len_inc;
                        end else begin
                            o_va = 1'b1;
                            o_tok_a.cls = CLS_FLOAT;
                            rebegin = 1'b1;
                        end
                    end
                    S_CHR, S_STR: begin
                        if (i_char == ((r_state == S_CHR) ? 8'h27 : 8'h22)) begin
                            o_va = 1'b1;
                            o_tok_a.cls = (r_state == S_CHR) ? CLS_CHAR : CLS_STRING;
                            o_vb = 1'b1;
                            o_tok_b = '{length: 16'd1, offset: r_off, col: n_col,
                                        line: n_line, kw: NOT_KEYWORD, cls: CLS_DELIM};
                            n_state = S_BEGIN;
                        end else begin
                            n_len = len_inc;
                            if (i_char == 8'h5C) begin
                                n_state = (r_state == S_CHR) ? S_CHR_ESC : S_STR_ESC;
                            end
                        end
                    end
                    S_CHR_ESC: begin
                        n_len = len_inc;
                        n_state = S_CHR;
                    end
                    S_STR_ESC: begin
                        n_len = len_inc;
                        n_state = S_STR;
                    end
                    S_BLOCK: begin
                        if (i_char == "*") begin
                            n_state = S_BLOCK_STAR;
                        end
                    end
                    S_BLOCK_STAR: begin
                        if (i_char == "/") begin
                            n_state = S_BEGIN;
                        end else if (i_char != "*") begin
                            n_state = S_BLOCK;
                        end
                    end
                    S_LINE: begin
                        if (i_char == 8'h0A) begin
                            n_state = S_BEGIN;
                        end
                    end
                    default: begin
                        o_tok_a.cls = CLS_OP;
                        if (i_char == "=") begin
                            o_va = 1'b1;
                            o_tok_a.length = len_inc;
                            n_len = len_inc;
                            n_state = S_BEGIN;
                        end else if (r_state == S_SLASH && i_char == "*") begin
                            n_state = S_BLOCK;
                        end else if (r_state == S_SLASH && i_char == "/") begin
                            n_state = S_LINE;
                        end else if (op_first != 8'd0 && i_char == op_first) begin
                            n_len = len_inc;
                            if (r_state == S_GT) begin
                                n_state = S_GTGT;
                            end else if (r_state == S_LT) begin
                                n_state = S_LTLT;
                            end else begin
                                o_va = 1'b1;
                                o_tok_a.length = len_inc;
                                n_state = S_BEGIN;
                            end
                        end else begin
                            o_va = 1'b1;
                            rebegin = 1'b1;
                        end
                    end
                endcase

                if (rebegin) begin
                    n_state = S_BEGIN;
                    o_tok_b = '{length: 16'd1, offset: r_off, col: n_col, line: n_line,
                                kw: NOT_KEYWORD, cls: CLS_DELIM};
                    if (is_letter || is_digit) begin
                        n_state    = is_letter ? S_WORD : S_INT;
                        n_word[0]  = i_char;
                        n_len      = 16'd1;
                        n_too_long = 1'b0;
                        n_tline    = n_line;
                        n_tcol     = n_col;
                        n_toff     = r_off;
                    end else begin
                        unique case (i_char)
                            8'h20, 8'h0A, 8'h09, 8'h0D: begin
                            end
                            "+", "-", "/", "*", "%", "&", "|", "!", ">", "<", "^", "=": begin
                                unique case (i_char)
                                    "+": n_state = S_PLUS;
                                    "-": n_state = S_MINUS;
                                    "/": n_state = S_SLASH;
                                    "*": n_state = S_STAR;
                                    "%": n_state = S_PCT;
                                    "&": n_state = S_AMP;
                                    "|": n_state = S_BAR;
                                    "!": n_state = S_BANG;
                                    ">": n_state = S_GT;
                                    "<": n_state = S_LT;
                                    "^": n_state = S_CARET;
                                    default: n_state = S_EQ;
                                endcase
                                n_len      = 16'd1;
                                n_too_long = 1'b0;
                                n_tline    = n_line;
                                n_tcol     = n_col;
                                n_toff     = r_off;
                            end
                            8'h27, 8'h22: begin
                                o_vb       = 1'b1;
                                n_state    = (i_char == 8'h22) ? S_STR : S_CHR;
                                n_len      = 16'd0;
                                n_too_long = 1'b0;
                                n_tline    = n_line;
                                n_tcol     = ncol;
                                n_toff     = r_off + 32'd1;
                            end
                            "(", ")", "{", "}", "[", "]", ":", ";", ",", ".", "#", "?": begin
                                o_vb = 1'b1;
                            end
                            default: begin
                                o_vb = 1'b1;
                                o_tok_b.cls = CLS_ERROR;
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_BEGIN;
            r_too_long <= 1'b0;
            r_len      <= '0;
            r_line     <= '0;
            r_col      <= '0;
            r_off      <= '0;
            r_tline    <= '0;
            r_tcol     <= '0;
            r_toff     <= '0;
        end else begin
            r_state    <= n_state;
            r_too_long <= n_too_long;
            r_len      <= n_len;
            r_line     <= n_line;
            r_col      <= n_col;
            r_off      <= n_off;
            r_tline    <= n_tline;
            r_tcol     <= n_tcol;
            r_toff     <= n_toff;
        end
        r_word <= n_word;
    end

endmodule

[sv/c_lexer_token_scanner.sv]
// ----------------------------------------------------------------------------
// c_lexer_token_scanner
// c source tokenizer, one byte per transfer, tokens with position and length
// ----------------------------------------------------------------------------
//  channel   dir  tdata                       tuser          tlast
//  s_axis    in   char_byte[7:0]              -              end_of_input
//  m_axis    out  token fields, see port      token_class    last_of_run
//
//  one byte is taken per cycle while the result queue has room for two tokens
//  a byte gives zero, one or two tokens; output drains one token per cycle while m_axis_tready is high
//  the four-entry result queue sets the rate: two-token bytes slow intake
//  to match the single output port; each token is registered in the queue before it is offered
//  synchronous active-low reset returns the lexer to its begin state
// ----------------------------------------------------------------------------
module c_lexer_token_scanner
    import clts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_byte
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // keyword_index, start_line, start_col, start_offset, token_length
    output logic [95:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser,   // token_class
    output logic        m_axis_tlast    // last_of_run
);

    logic        in_xfer, out_xfer;
    logic        va, vb;
    t_tok        tok_a, tok_b;
    t_tok        e0, e1;
    logic        e0_last;
    logic [1:0]  n_push;
    t_tok        r_q [4];
    logic        r_q_last [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_count;

    assign s_axis_tready = r_count <= 3'd2;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_count != 3'd0;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {6'b000000, r_q[r_rp].length, r_q[r_rp].offset, r_q[r_rp].col,
                            r_q[r_rp].line, r_q[r_rp].kw};
    assign m_axis_tuser  = r_q[r_rp].cls;
    assign m_axis_tlast  = r_q_last[r_rp];

    clts_lexer u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_char   (s_axis_tdata),
        .i_eoi    (s_axis_tlast),
        .o_va     (va),
        .o_tok_a  (tok_a),
        .o_vb     (vb),
        .o_tok_b  (tok_b)
    );

    assign e0      = va ? tok_a : tok_b;
    assign e1      = tok_b;
    assign e0_last = !(va && vb);
    assign n_push  = {1'b0, va} + {1'b0, vb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + n_push;
            r_rp    <= r_rp + {1'b0, out_xfer};
            r_count <= r_count + {1'b0, n_push} - {2'b00, out_xfer};
        end
        if (n_push != 2'd0) begin
            r_q[r_wp]      <= e0;
            r_q_last[r_wp] <= e0_last;
        end
        if (n_push == 2'd2) begin
            r_q[r_wp + 2'd1]      <= e1;
            r_q_last[r_wp + 2'd1] <= 1'b1;
        end
    end

`include "c_lexer_token_scanner_assert.svh"

    `CLTS_ASSERT_ALWAYS(a_count_max, r_count <= 3'd4, "result queue overflow")
    `CLTS_ASSERT_ALWAYS(a_pair_room, !(in_xfer && r_count > 3'd2), "byte taken without room")
    `CLTS_ASSERT_NEXT(a_drain, out_xfer && !in_xfer, r_count == $past(r_count) - 3'd1, "drain")

endmodule
